// ===== design/blfb_pkg.sv =====
package blfb_pkg;

    localparam int ROWS_PER_PAGE = 8;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPW           = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } t_kind;

    // One pixel plot request from the line stepper to the framebuffer.
    typedef struct packed {
        logic       valid;
        logic [2:0] page;
        logic [6:0] column;
        logic [2:0] bit_sel;
        logic       ink;
        logic       last;
    } t_plot_req;

    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] pixel_byte;
        logic       last;
    } t_plot_res;

endpackage

// ===== design/blfb_plot.sv =====
module blfb_plot import blfb_pkg::*; #(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_plot_req i_req,
    output t_plot_res o_res,
    output logic      o_res_valid,
    output logic      o_clear_busy
);

    localparam int DEPTH = PANEL_WIDTH * PANEL_PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AWX   = AW + 9;

    logic [7:0]     r_mem [DEPTH];
    logic [AWX-1:0] rd_addr_w;
    logic [AW-1:0]  rd_addr;
    t_plot_req      r_s1;
    logic [AW-1:0]  r_s1_addr;
    logic [7:0]     r_rd_data;
    logic           r_fwd_hit;
    logic [7:0]     r_fwd_data;
    logic           r_clearing;
    logic [AW-1:0]  r_clr_addr;
    logic [7:0]     base_byte;
    logic [7:0]     bit_mask;
    logic [7:0]     new_byte;

    assign rd_addr_w = AWX'(i_req.page) * AWX'(PANEL_WIDTH) + AWX'(i_req.column);
    assign rd_addr   = rd_addr_w[AW-1:0];

    // take the byte written back by the previous plot if the read hit the same entry
    assign base_byte = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign bit_mask  = 8'b1 << r_s1.bit_sel;
    assign new_byte  = r_s1.ink ? (base_byte | bit_mask) : (base_byte & ~bit_mask);

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (r_s1.valid) begin
            r_mem[r_s1_addr] <= new_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1       <= '0;
            r_fwd_hit  <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_s1      <= i_req;
            r_fwd_hit <= r_s1.valid && (r_s1_addr == rd_addr);
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= rd_addr;
        r_fwd_data <= new_byte;
    end

    assign o_res_valid       = r_s1.valid;
    assign o_res.page        = r_s1.page;
    assign o_res.column      = r_s1.column;
    assign o_res.pixel_byte  = new_byte;
    assign o_res.last        = r_s1.last;
    assign o_clear_busy      = r_clearing;

endmodule

// ===== design/bresenham_line_framebuffer_top.sv =====
// Bresenham line drawer into a page-organized monochrome framebuffer of PANEL_PAGES pages by
// PANEL_WIDTH columns. A start request loads both endpoints and the ink and plots the first
// pixel; each step request plots the next pixel, and a step with no line active gives no
// result. Each plot reads the framebuffer byte, sets or clears one bit and writes it back;
// the result is that byte with its page and column, last marking the far endpoint. After
// reset the framebuffer is swept to zero, one byte per cycle, and no request is taken until
// the sweep is done. Afterwards one request is taken every cycle while the result queue has
// room: the read-modify-write of the framebuffer is split into a registered read and a
// write-back, with the byte being written forwarded to a read of the same address, and a
// four-entry result queue absorbs output stalls; each result is registered, then queued.
module bresenham_line_framebuffer_top import blfb_pkg::*; #(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [0:0] i_kind,
    input  logic [6:0] i_x_start,
    input  logic [5:0] i_y_start,
    input  logic [6:0] i_x_end,
    input  logic [5:0] i_y_end,
    input  logic [0:0] i_ink,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_page,
    output logic [6:0] o_column,
    output logic [7:0] o_pixel_byte,
    output logic [0:0] o_last
);

    localparam int PANEL_ROWS = PANEL_PAGES * ROWS_PER_PAGE;

    logic in_fire;
    logic clear_busy;
    logic res_valid;
    t_plot_res res;
    t_plot_req req;

    // line state
    logic [6:0] r_cur_x, n_cur_x, r_goal_x, n_goal_x;
    logic [5:0] r_cur_y, n_cur_y, r_goal_y, n_goal_y;
    logic       r_dir_x_neg, n_dir_x_neg, r_dir_y_neg, n_dir_y_neg;
    logic [7:0] r_twice_dx, n_twice_dx;
    logic [6:0] r_twice_dy, n_twice_dy;
    logic signed [9:0] r_err, n_err;
    logic       r_x_major, n_x_major, r_ink, n_ink, r_busy, n_busy;

    // start decode
    logic [6:0] cl_xs, cl_xe, adx;
    logic [5:0] cl_ys, cl_ye, ady;
    logic signed [7:0] dx_s;
    logic signed [6:0] dy_s;
    logic       s_x_major, s_done;
    logic signed [9:0] s_err;

    // step decode
    logic       err_nonneg, t_done;
    logic [6:0] t_x;
    logic [5:0] t_y;
    logic signed [9:0] err_a, t_err;

    // result queue
    t_plot_res          r_q [QUEUE_DEPTH];
    logic [QPW-1:0]     r_head, r_tail;
    logic [QPW:0]       r_cnt;
    logic               pop;

    assign in_fire = i_in_valid && o_in_ready;

    // saturate endpoints to the panel
    assign cl_xs = (9'(i_x_start) >= 9'(PANEL_WIDTH)) ? 7'(PANEL_WIDTH - 1) : i_x_start;
    assign cl_xe = (9'(i_x_end) >= 9'(PANEL_WIDTH)) ? 7'(PANEL_WIDTH - 1) : i_x_end;
    assign cl_ys = (8'(i_y_start) >= 8'(PANEL_ROWS)) ? 6'(PANEL_ROWS - 1) : i_y_start;
    assign cl_ye = (8'(i_y_end) >= 8'(PANEL_ROWS)) ? 6'(PANEL_ROWS - 1) : i_y_end;

    assign dx_s = $signed({1'b0, cl_xe}) - $signed({1'b0, cl_xs});
    assign dy_s = $signed({1'b0, cl_ye}) - $signed({1'b0, cl_ys});
    assign adx  = dx_s[7] ? 7'(-dx_s) : dx_s[6:0];
    assign ady  = dy_s[6] ? 6'(-dy_s) : dy_s[5:0];
    assign s_x_major = adx > 7'(ady);
    assign s_err = s_x_major ? $signed(10'({ady, 1'b0}) - 10'(adx))
                             : $signed(10'({adx, 1'b0}) - 10'(ady));
    assign s_done = s_x_major ? (cl_xs == cl_xe) : (cl_ys == cl_ye);

    assign err_nonneg = !r_err[9];

    always_comb begin
        t_x   = r_cur_x;
        t_y   = r_cur_y;
        err_a = r_err;
        if (r_x_major) begin
            if (err_nonneg) begin
                t_y   = r_dir_y_neg ? r_cur_y - 6'd1 : r_cur_y + 6'd1;
                err_a = r_err - $signed(10'(r_twice_dx));
            end
            t_x   = r_dir_x_neg ? r_cur_x - 7'd1 : r_cur_x + 7'd1;
            t_err = err_a + $signed(10'(r_twice_dy));
            t_done = (t_x == r_goal_x);
        end else begin
            if (err_nonneg) begin
                t_x   = r_dir_x_neg ? r_cur_x - 7'd1 : r_cur_x + 7'd1;
                err_a = r_err - $signed(10'(r_twice_dy));
            end
            t_y   = r_dir_y_neg ? r_cur_y - 6'd1 : r_cur_y + 6'd1;
            t_err = err_a + $signed(10'(r_twice_dx));
            t_done = (t_y == r_goal_y);
        end
    end

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_goal_x    = r_goal_x;
        n_goal_y    = r_goal_y;
        n_dir_x_neg = r_dir_x_neg;
        n_dir_y_neg = r_dir_y_neg;
        n_twice_dx  = r_twice_dx;
        n_twice_dy  = r_twice_dy;
        n_err       = r_err;
        n_x_major   = r_x_major;
        n_ink       = r_ink;
        n_busy      = r_busy;
        req         = '0;
        if (in_fire) begin
            if (t_kind'(i_kind) == KIND_START) begin
                n_cur_x     = cl_xs;
                n_cur_y     = cl_ys;
                n_goal_x    = cl_xe;
                n_goal_y    = cl_ye;
                n_dir_x_neg = dx_s[7];
                n_dir_y_neg = dy_s[6];
                n_twice_dx  = {adx, 1'b0};
                n_twice_dy  = {ady, 1'b0};
                n_err       = s_err;
                n_x_major   = s_x_major;
                n_ink       = i_ink[0];
                n_busy      = !s_done;
                req.valid   = 1'b1;
                req.last    = s_done;
            end else if (r_busy) begin
                n_cur_x   = t_x;
                n_cur_y   = t_y;
                n_err     = t_err;
                n_busy    = !t_done;
                req.valid = 1'b1;
                req.last  = t_done;
            end
        end
        req.page    = n_cur_y[5:3];
        req.column  = n_cur_x;
        req.bit_sel = n_cur_y[2:0];
        req.ink     = n_ink;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_dir_x_neg <= 1'b0;
            r_dir_y_neg <= 1'b0;
            r_twice_dx  <= '0;
            r_twice_dy  <= '0;
            r_err       <= '0;
            r_x_major   <= 1'b0;
            r_ink       <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_goal_x    <= n_goal_x;
            r_goal_y    <= n_goal_y;
            r_dir_x_neg <= n_dir_x_neg;
            r_dir_y_neg <= n_dir_y_neg;
            r_twice_dx  <= n_twice_dx;
            r_twice_dy  <= n_twice_dy;
            r_err       <= n_err;
            r_x_major   <= n_x_major;
            r_ink       <= n_ink;
            r_busy      <= n_busy;
        end
    end

    blfb_plot #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_PAGES (PANEL_PAGES)
    ) u_plot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_res        (res),
        .o_res_valid  (res_valid),
        .o_clear_busy (clear_busy)
    );

    // hold back requests unless the queue has room for everything in flight
    assign o_in_ready = !clear_busy
                     && (((QPW+2)'(r_cnt) + (QPW+2)'(res_valid)) < (QPW+2)'(QUEUE_DEPTH));

    assign pop = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_q[r_tail] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (res_valid) begin
                r_tail <= r_tail + QPW'(1);
            end
            if (pop) begin
                r_head <= r_head + QPW'(1);
            end
            r_cnt <= r_cnt + (QPW+1)'(res_valid) - (QPW+1)'(pop);
        end
    end

    assign o_out_valid  = (r_cnt != '0);
    assign o_page       = r_q[r_head].page;
    assign o_column     = r_q[r_head].column;
    assign o_pixel_byte = r_q[r_head].pixel_byte;
    assign o_last       = r_q[r_head].last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_start_plots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (t_kind'(i_kind) == KIND_START)) |=> res_valid)
        else $error("start request produced no plot");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.last) |-> !r_busy)
        else $error("line still active after its last pixel");

endmodule
